// ===== src/swrs_pkg.sv =====
// ----------------------------------------------------------------------------
// swrs_pkg
// Shared types and fixed constants of the sliding-window rank-sum block.
// ----------------------------------------------------------------------------
package swrs_pkg;

    // U statistics are kept modulo 2^22 in half units
    localparam int U_W = 22;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD_OLD,
        ST_WR_OLD,
        ST_RD_NEW,
        ST_WR_NEW,
        ST_SWP_GO,
        ST_SWEEP,
        ST_ADJ,
        ST_FIN,
        ST_OUT
    } state_t;

    // Status of the histogram sweep unit
    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

endpackage

// ===== src/swrs_ram.sv =====
// ----------------------------------------------------------------------------
// swrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swrs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/swrs_sweep.sv =====
// ----------------------------------------------------------------------------
// swrs_sweep
// Walks one histogram bin by bin and accumulates the doubled rank weights
// 2*|y > v| + |y == v| for the new and the old value at once.
// ----------------------------------------------------------------------------
module swrs_sweep #(
    parameter int VB = 10,
    parameter int CW = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VB-1:0]            nv,
    input  logic [VB-1:0]            ov,
    input  logic [CW-1:0]            rdata,
    output logic [VB-1:0]            raddr,
    output logic [CW:0]              wn,
    output logic [CW:0]              wo,
    output swrs_pkg::sweep_stat_t    stat
);

    localparam logic [VB-1:0] LAST = {VB{1'b1}};

    logic [VB-1:0] cnt_reg;
    logic          issue_reg;
    logic          vld_reg;
    logic [VB-1:0] kd_reg;
    logic          done_reg;
    logic [CW:0]   wn_reg;
    logic [CW:0]   wo_reg;
    logic [CW:0]   h2;
    logic [CW:0]   h1;

    assign h1 = {1'b0, rdata};
    assign h2 = {rdata, 1'b0};

    // Issue addresses, then accumulate the registered read data of each returning bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            issue_reg <= 1'b0;
            vld_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg && (kd_reg == LAST);
            vld_reg  <= issue_reg;
            if (start)
            begin
                cnt_reg   <= '0;
                issue_reg <= 1'b1;
            end
            else if (issue_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kd_reg <= cnt_reg;
        if (start)
        begin
            wn_reg <= '0;
            wo_reg <= '0;
        end
        else if (vld_reg)
        begin
            if (kd_reg > nv)
            begin
                wn_reg <= wn_reg + h2;
            end
            else if (kd_reg == nv)
            begin
                wn_reg <= wn_reg + h1;
            end
            if (kd_reg > ov)
            begin
                wo_reg <= wo_reg + h2;
            end
            else if (kd_reg == ov)
            begin
                wo_reg <= wo_reg + h1;
            end
        end
    end

    assign raddr     = cnt_reg;
    assign wn        = wn_reg;
    assign wo        = wo_reg;
    assign stat.busy = issue_reg || vld_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/sliding_window_rank_sum_u.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rank_sum_u
// Sliding-window Mann-Whitney U over two histogrammed groups, updated
// incrementally by sweeping the partner histogram.
//
//  channel   dir  fields
//  s_axis    in   s_tdata: old_a_present, old_a_value, new_a_present,
//                 new_a_value, old_b_present, old_b_value, new_b_present,
//                 new_b_value
//  m_axis    out  m_tdata: min_u_doubled, size_a, size_b, reliable,
//                 changed, bad_removal
//  apb       in   min_reliable_size at byte address 0
//
// An item is accepted, then each group that is looked at passes through
// the read-old, write-old, read-new and write-new states (a group left
// untouched only through read-old); per changed group the bin sweep over
// the partner histogram is started and run and both U updates are
// applied; last the result is loaded. The sweep through the single read
// port of each histogram RAM sets the item rate. After reset a clearing
// pass zeroes both RAMs; no item is taken during it. A stalled result is
// held in the output register; the next item is taken meanwhile and its
// result waits in the last state until the register is free.
// ----------------------------------------------------------------------------
module sliding_window_rank_sum_u #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_WINDOW = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // old_a_present, old_a_value, new_a_present, new_a_value,
    // old_b_present, old_b_value, new_b_present, new_b_value; zero pad
    input  logic [((4+4*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // min_u_doubled, size_a, size_b, reliable, changed, bad_removal; pad
    output logic [((swrs_pkg::U_W+2*$clog2(MAX_WINDOW+1)+3+7)/8)*8-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VB    = VALUE_BITS;
    localparam int SW    = $clog2(MAX_WINDOW + 1);
    localparam int UW    = swrs_pkg::U_W;
    localparam int BINS  = 1 << VB;
    localparam int GW    = 2 + 2 * VB;
    localparam int IN_W  = ((4 + 4 * VB + 7) / 8) * 8;
    localparam int OUT_W = ((UW + 2 * SW + 3 + 7) / 8) * 8;
    localparam int PW    = (UW > 2 * SW + 1) ? UW : 2 * SW + 1;
    localparam logic [SW-1:0] MAXW   = SW'(MAX_WINDOW);
    localparam logic [SW-1:0] RELRST = SW'(10);
    localparam logic [VB-1:0] LAST   = VB'(BINS - 1);

    swrs_pkg::state_t state_reg, state_next;

    logic [IN_W-1:0] in_reg;
    logic            grp_reg;
    logic            rem_reg;
    logic            ins_reg;
    logic            chg_reg;
    logic            bad_reg;
    logic [SW-1:0]   ca_reg, cb_reg;
    logic [UW-1:0]   ua_reg, ub_reg;
    logic [VB-1:0]   clr_reg;
    logic [SW-1:0]   rel_reg;
    logic            mv_reg;
    logic [OUT_W-1:0] mdata_reg;

    logic [GW-1:0] gsl;
    logic          op, np;
    logic [VB-1:0] ov, nv;
    logic          skip;
    logic [SW-1:0] own_cnt;
    logic [SW-1:0] own_rd;
    logic          ins_now;
    logic          out_ld;

    logic          we_a, we_b;
    logic [VB-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
    logic [SW-1:0] wdata_a, wdata_b, rdata_a, rdata_b;
    logic          own_we;
    logic [VB-1:0] own_waddr, own_raddr;
    logic [SW-1:0] own_wdata;

    logic                  swp_start;
    logic [VB-1:0]         swp_addr;
    logic [SW-1:0]         swp_rdata;
    logic [SW:0]           wn, wo;
    swrs_pkg::sweep_stat_t swp_stat;

    logic [UW-1:0] u_other, u_adj, u_own;
    logic [PW-1:0] prod;
    logic [UW-1:0] min_u;
    logic          cfg_wr;

    // Current group's fields
    assign gsl     = in_reg[grp_reg * GW +: GW];
    assign op      = gsl[0];
    assign ov      = gsl[VB:1];
    assign np      = gsl[VB+1];
    assign nv      = gsl[2*VB+1:VB+2];
    assign skip    = (op == np) && (!op || (ov == nv));
    assign own_cnt = grp_reg ? cb_reg : ca_reg;
    assign own_rd  = grp_reg ? rdata_b : rdata_a;
    assign ins_now = np && (own_cnt < MAXW);
    assign out_ld  = (state_reg == swrs_pkg::ST_OUT) && (!mv_reg || m_tready);
    assign u_other = grp_reg ? ua_reg : ub_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swrs_pkg::ST_CLR:
                if (clr_reg == LAST) state_next = swrs_pkg::ST_IDLE;
            swrs_pkg::ST_IDLE:
                if (s_tvalid) state_next = swrs_pkg::ST_RD_OLD;
            swrs_pkg::ST_RD_OLD:
                if (skip && grp_reg) state_next = swrs_pkg::ST_OUT;
                else if (!skip) state_next = swrs_pkg::ST_WR_OLD;
            swrs_pkg::ST_WR_OLD:
                state_next = swrs_pkg::ST_RD_NEW;
            swrs_pkg::ST_RD_NEW:
                state_next = swrs_pkg::ST_WR_NEW;
            swrs_pkg::ST_WR_NEW:
                if (rem_reg || ins_now) state_next = swrs_pkg::ST_SWP_GO;
                else if (grp_reg) state_next = swrs_pkg::ST_OUT;
                else state_next = swrs_pkg::ST_RD_OLD;
            swrs_pkg::ST_SWP_GO:
                state_next = swrs_pkg::ST_SWEEP;
            swrs_pkg::ST_SWEEP:
                if (swp_stat.done) state_next = swrs_pkg::ST_ADJ;
            swrs_pkg::ST_ADJ:
                state_next = swrs_pkg::ST_FIN;
            swrs_pkg::ST_FIN:
                state_next = grp_reg ? swrs_pkg::ST_OUT : swrs_pkg::ST_RD_OLD;
            swrs_pkg::ST_OUT:
                if (out_ld) state_next = swrs_pkg::ST_IDLE;
            default:
                state_next = swrs_pkg::ST_CLR;
        endcase
    end

    // Memory and handshake controls
    always_comb
    begin
        s_tready  = 1'b0;
        swp_start = 1'b0;
        own_we    = 1'b0;
        own_waddr = ov;
        own_wdata = own_rd - 1'b1;
        own_raddr = ov;
        unique case (state_reg)
            swrs_pkg::ST_IDLE:   s_tready = 1'b1;
            swrs_pkg::ST_RD_OLD: own_raddr = ov;
            swrs_pkg::ST_WR_OLD: own_we = op && (own_rd != '0);
            swrs_pkg::ST_RD_NEW: own_raddr = nv;
            swrs_pkg::ST_WR_NEW:
            begin
                own_we    = ins_now;
                own_waddr = nv;
                own_wdata = own_rd + 1'b1;
            end
            swrs_pkg::ST_SWP_GO: swp_start = 1'b1;
            default: ;
        endcase
    end

    // Route own accesses and sweep reads to the two histograms
    always_comb
    begin
        we_a    = (state_reg == swrs_pkg::ST_CLR) || (own_we && !grp_reg);
        we_b    = (state_reg == swrs_pkg::ST_CLR) || (own_we && grp_reg);
        waddr_a = (state_reg == swrs_pkg::ST_CLR) ? clr_reg : own_waddr;
        waddr_b = waddr_a;
        wdata_a = (state_reg == swrs_pkg::ST_CLR) ? '0 : own_wdata;
        wdata_b = wdata_a;
        raddr_a = grp_reg ? swp_addr : own_raddr;
        raddr_b = grp_reg ? own_raddr : swp_addr;
        swp_rdata = grp_reg ? rdata_a : rdata_b;
    end

    swrs_ram #(.WIDTH(SW), .DEPTH(BINS)) u_hist_a (
        .clk(clk), .we(we_a), .waddr(waddr_a), .wdata(wdata_a),
        .raddr(raddr_a), .rdata(rdata_a)
    );

    swrs_ram #(.WIDTH(SW), .DEPTH(BINS)) u_hist_b (
        .clk(clk), .we(we_b), .waddr(waddr_b), .wdata(wdata_b),
        .raddr(raddr_b), .rdata(rdata_b)
    );

    swrs_sweep #(.VB(VB), .CW(SW)) u_sweep (
        .clk(clk), .rst_n(rst_n), .start(swp_start), .nv(nv), .ov(ov),
        .rdata(swp_rdata), .raddr(swp_addr), .wn(wn), .wo(wo), .stat(swp_stat)
    );

    // Partner U adjust and own U recompute
    assign u_adj = u_other + (ins_reg ? UW'(wn) : '0) - (rem_reg ? UW'(wo) : '0);
    assign prod  = PW'(ca_reg) * PW'(cb_reg);
    assign u_own = UW'({prod[PW-2:0], 1'b0}) - u_other;
    assign min_u = (ua_reg < ub_reg) ? ua_reg : ub_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swrs_pkg::ST_CLR;
            clr_reg   <= '0;
            grp_reg   <= 1'b0;
            ca_reg    <= '0;
            cb_reg    <= '0;
            ua_reg    <= '0;
            ub_reg    <= '0;
            rel_reg   <= RELRST;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == swrs_pkg::ST_CLR) clr_reg <= clr_reg + 1'b1;
            if (cfg_wr && !paddr[2]) rel_reg <= pwdata[SW-1:0];
            if (state_reg == swrs_pkg::ST_IDLE) grp_reg <= 1'b0;
            if ((state_reg == swrs_pkg::ST_RD_OLD && skip && !grp_reg) ||
                (state_reg == swrs_pkg::ST_WR_NEW && !rem_reg && !ins_now && !grp_reg) ||
                (state_reg == swrs_pkg::ST_FIN && !grp_reg))
            begin
                grp_reg <= 1'b1;
            end
            if (state_reg == swrs_pkg::ST_WR_OLD && op && (own_rd != '0))
            begin
                if (grp_reg) cb_reg <= cb_reg - 1'b1;
                else ca_reg <= ca_reg - 1'b1;
            end
            if (state_reg == swrs_pkg::ST_WR_NEW && ins_now)
            begin
                if (grp_reg) cb_reg <= cb_reg + 1'b1;
                else ca_reg <= ca_reg + 1'b1;
            end
            if (state_reg == swrs_pkg::ST_ADJ)
            begin
                if (grp_reg) ua_reg <= u_adj;
                else ub_reg <= u_adj;
            end
            if (state_reg == swrs_pkg::ST_FIN)
            begin
                if (grp_reg) ub_reg <= u_own;
                else ua_reg <= u_own;
            end
            if (out_ld) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
    end

    // Item payload, per-group flags and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == swrs_pkg::ST_IDLE)
        begin
            in_reg  <= s_tdata;
            chg_reg <= 1'b0;
            bad_reg <= 1'b0;
        end
        if (state_reg == swrs_pkg::ST_RD_OLD)
        begin
            rem_reg <= 1'b0;
            ins_reg <= 1'b0;
        end
        if (state_reg == swrs_pkg::ST_WR_OLD && op)
        begin
            rem_reg <= (own_rd != '0);
            if (own_rd == '0) bad_reg <= 1'b1;
        end
        if (state_reg == swrs_pkg::ST_WR_NEW)
        begin
            ins_reg <= ins_now;
            if (rem_reg || ins_now) chg_reg <= 1'b1;
        end
        if (out_ld)
        begin
            mdata_reg <= OUT_W'({bad_reg, chg_reg,
                                 (ca_reg >= rel_reg) && (cb_reg >= rel_reg),
                                 cb_reg, ca_reg, min_u});
        end
    end

    // Configuration port
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : 32'(rel_reg);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // Checks
    a_cnt_a: assert property (@(posedge clk) disable iff (!rst_n) ca_reg <= MAXW)
        else $error("group A size above window");
    a_cnt_b: assert property (@(posedge clk) disable iff (!rst_n) cb_reg <= MAXW)
        else $error("group B size above window");
    a_load: assert property (@(posedge clk) disable iff (!rst_n) out_ld |=> m_tvalid)
        else $error("result load lost");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        swp_stat.done |-> state_reg == swrs_pkg::ST_SWEEP)
        else $error("sweep finished outside sweep state");

endmodule
